// File: design/dlq_pkg.sv
`timescale 1ns / 1ps
package dlq_pkg;

    localparam int DATA_W      = 16;
    localparam int MAX_RESULTS = 32;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_TICK     = 2'd1,
        CMD_SERVICE  = 2'd2,
        CMD_NONE     = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        STAT_SCHEDULED = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EXPIRED   = 3'd2,
        STAT_NOTHING   = 3'd3,
        STAT_TICK      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_TICK,
        S_SERVE
    } t_state;

    typedef struct packed {
        logic [1:0]        command;
        logic [DATA_W-1:0] handle;
        logic [DATA_W-1:0] delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] expired_handle;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic    load;
        logic    step;
        logic    insert;
        logic    tick;
        logic    pop;
        logic    out_load;
        t_status out_status;
        logic    out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic walk_go;
        logic head_exp;
        logic next_exp;
        logic slot_free;
    } t_dp_sts;

endpackage

// File: design/dlq_ctrl.sv
`timescale 1ns / 1ps
module dlq_ctrl
    import dlq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_command,
    output logic     o_in_ready,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic [RES_W-1:0] r_nres, n_nres;
    logic final_pop;

    assign final_pop = !i_sts.next_exp || (r_nres == RES_W'(MAX_RESULTS - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nres  <= '0;
        end else begin
            r_state <= n_state;
            r_nres  <= n_nres;
        end
    end

    always_comb begin
        n_state = r_state;
        n_nres  = r_nres;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_nres = '0;
                    unique case (t_command'(i_command))
                        CMD_SCHEDULE: n_state = S_WALK;
                        CMD_TICK:     n_state = S_TICK;
                        CMD_SERVICE:  n_state = S_SERVE;
                        CMD_NONE:     n_state = S_IDLE;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                if ((i_sts.full || !i_sts.walk_go) && i_sts.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (i_sts.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SERVE: begin
                if (i_sts.slot_free) begin
                    if (!i_sts.head_exp || final_pop) begin
                        n_state = S_IDLE;
                    end
                    n_nres = r_nres + RES_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.out_status = STAT_SCHEDULED;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_WALK: begin
                if (i_sts.full) begin
                    o_cmd.out_load   = i_sts.slot_free;
                    o_cmd.out_status = STAT_FULL;
                    o_cmd.out_last   = 1'b1;
                end else if (i_sts.walk_go) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.insert     = i_sts.slot_free;
                    o_cmd.out_load   = i_sts.slot_free;
                    o_cmd.out_status = STAT_SCHEDULED;
                    o_cmd.out_last   = 1'b1;
                end
            end
            S_TICK: begin
                o_cmd.tick       = i_sts.slot_free;
                o_cmd.out_load   = i_sts.slot_free;
                o_cmd.out_status = STAT_TICK;
                o_cmd.out_last   = 1'b1;
            end
            S_SERVE: begin
                o_cmd.out_load = i_sts.slot_free;
                if (i_sts.head_exp) begin
                    o_cmd.pop        = i_sts.slot_free;
                    o_cmd.out_status = STAT_EXPIRED;
                    o_cmd.out_last   = final_pop;
                end else begin
                    o_cmd.out_status = STAT_NOTHING;
                    o_cmd.out_last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: design/dlq_dp.sv
`timescale 1ns / 1ps
module dlq_dp
    import dlq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_delta [QUEUE_DEPTH];
    logic [DATA_W-1:0] r_handle [QUEUE_DEPTH];
    logic [DATA_W-1:0] n_delta [QUEUE_DEPTH];
    logic [DATA_W-1:0] n_handle [QUEUE_DEPTH];
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_pos, n_pos;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_hnd;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [DATA_W-1:0] sel_delta;
    logic              seen;

    always_comb begin
        sel_delta = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (r_pos == CW'(i)) begin
                sel_delta = r_delta[i];
            end
        end
    end

    assign o_sts.full      = (r_count == CW'(QUEUE_DEPTH));
    assign o_sts.walk_go   = (r_pos < r_count) && (sel_delta < r_rem);
    assign o_sts.head_exp  = (r_count != '0) && (r_delta[0] == '0);
    assign o_sts.next_exp  = (r_count > CW'(1)) && (r_delta[1] == '0);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_rem   = r_rem;
        seen    = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_delta[i]  = r_delta[i];
            n_handle[i] = r_handle[i];
        end
        if (i_cmd.load) begin
            n_pos = '0;
            n_rem = i_in_data.delay_ticks;
        end
        if (i_cmd.step) begin
            n_pos = r_pos + CW'(1);
            n_rem = r_rem - sel_delta;
        end
        if (i_cmd.insert) begin
            n_count = r_count + CW'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (CW'(i) > r_pos) begin
                    n_delta[i]  = r_delta[(i == 0) ? 0 : i - 1];
                    n_handle[i] = r_handle[(i == 0) ? 0 : i - 1];
                end
                if ((CW'(i) == r_pos + CW'(1)) && (r_pos < r_count)) begin
                    n_delta[i] = r_delta[(i == 0) ? 0 : i - 1] - r_rem;
                end
                if (CW'(i) == r_pos) begin
                    n_delta[i]  = r_rem;
                    n_handle[i] = r_hnd;
                end
            end
        end
        if (i_cmd.tick) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (!seen && (CW'(i) < r_count) && (r_delta[i] != '0)) begin
                    n_delta[i] = r_delta[i] - DATA_W'(1);
                    seen = 1'b1;
                end
            end
        end
        if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_delta[i]  = r_delta[i + 1];
                n_handle[i] = r_handle[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_delta[i]  <= n_delta[i];
            r_handle[i] <= n_handle[i];
        end
        r_pos <= n_pos;
        r_rem <= n_rem;
        if (i_cmd.load) begin
            r_hnd <= i_in_data.handle;
        end
        if (i_cmd.out_load) begin
            r_out.status         <= i_cmd.out_status;
            r_out.expired_handle <= (i_cmd.out_status == STAT_EXPIRED) ? r_handle[0] : '0;
            r_out.last           <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_count < CW'(QUEUE_DEPTH)))
        else $error("insert into full queue");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0) && (r_delta[0] == '0))
        else $error("pop of unexpired head");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");
`endif

endmodule

// File: design/delta_list_timer_queue_top.sv
`timescale 1ns / 1ps
// tick and table-full schedule: a single result, registered once the output slot is free
// schedule: n entries walked one per cycle through the delta chain
// service: one expired handle per cycle from the head cell while the output slot is free, up to 32 per request
// a new request is taken once the previous one has finished and loaded its last result
// synchronous active-low reset empties the queue and drops any pending result
module delta_list_timer_queue_top
    import dlq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dlq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dlq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
